// ===== rtl/spob_pkg.sv =====
// ----------------------------------------------------------------------------
// spob_pkg
// Shared types and constants of the shape overlay blend unit: register map,
// shape kind codes, configuration word and blend arithmetic constants.
// ----------------------------------------------------------------------------
package spob_pkg;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_SHAPE_KIND  = 3'd0;
   localparam logic [2:0] REG_ANCHOR_X    = 3'd1;
   localparam logic [2:0] REG_ANCHOR_Y    = 3'd2;
   localparam logic [2:0] REG_EXTENT_X    = 3'd3;
   localparam logic [2:0] REG_EXTENT_Y    = 3'd4;
   localparam logic [2:0] REG_FILL_COLOR  = 3'd5;
   localparam logic [2:0] REG_BLEND_ALPHA = 3'd6;

   localparam int CSR_ADDR_BITS = 5;

   // shape kinds
   localparam logic [2:0] KIND_POINT     = 3'd0;
   localparam logic [2:0] KIND_LINE      = 3'd1;
   localparam logic [2:0] KIND_OUTLINE   = 3'd2;
   localparam logic [2:0] KIND_FILL_RECT = 3'd3;
   localparam logic [2:0] KIND_RING      = 3'd4;
   localparam logic [2:0] KIND_DISK      = 3'd5;

   // blend: percent scale and exact reciprocal of 100 for sums up to 25500
   localparam logic [6:0]  PCT_FULL    = 7'd100;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam int          MIX_BITS    = 15;
   localparam int          SCALED_BITS = 28;

   // pipeline depth from input register to output register
   localparam int STAGES = 7;

   typedef struct packed {
      logic [2:0]         shape_kind;
      logic signed [12:0] anchor_x;
      logic signed [12:0] anchor_y;
      logic signed [12:0] extent_x;
      logic signed [12:0] extent_y;
      logic [23:0]        fill_color;
      logic [6:0]         blend_alpha;
   } cfg_type;

endpackage

// ===== rtl/spob_csr.sv =====
// ----------------------------------------------------------------------------
// spob_csr
// Configuration register file behind an APB-style port. pready is tied high.
// ----------------------------------------------------------------------------
module spob_csr
   import spob_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SHAPE_KIND:  cfg_in.shape_kind  = csr_pwdata[2:0];
            REG_ANCHOR_X:    cfg_in.anchor_x    = $signed(csr_pwdata[12:0]);
            REG_ANCHOR_Y:    cfg_in.anchor_y    = $signed(csr_pwdata[12:0]);
            REG_EXTENT_X:    cfg_in.extent_x    = $signed(csr_pwdata[12:0]);
            REG_EXTENT_Y:    cfg_in.extent_y    = $signed(csr_pwdata[12:0]);
            REG_FILL_COLOR:  cfg_in.fill_color  = csr_pwdata[23:0];
            REG_BLEND_ALPHA: cfg_in.blend_alpha = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_kind  <= KIND_POINT;
         cfg_ff.anchor_x    <= '0;
         cfg_ff.anchor_y    <= '0;
         cfg_ff.extent_x    <= '0;
         cfg_ff.extent_y    <= '0;
         cfg_ff.fill_color  <= 24'hFFFFFF;
         cfg_ff.blend_alpha <= PCT_FULL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_SHAPE_KIND:  csr_prdata = 32'(cfg_ff.shape_kind);
         REG_ANCHOR_X:    csr_prdata = 32'(unsigned'(cfg_ff.anchor_x));
         REG_ANCHOR_Y:    csr_prdata = 32'(unsigned'(cfg_ff.anchor_y));
         REG_EXTENT_X:    csr_prdata = 32'(unsigned'(cfg_ff.extent_x));
         REG_EXTENT_Y:    csr_prdata = 32'(unsigned'(cfg_ff.extent_y));
         REG_FILL_COLOR:  csr_prdata = 32'(cfg_ff.fill_color);
         REG_BLEND_ALPHA: csr_prdata = 32'(cfg_ff.blend_alpha);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/spob_cover.sv =====
// ----------------------------------------------------------------------------
// spob_cover
// Coverage test, stages 0 to 3: input register, products, sums, compares.
// Line pixels use trunc(N/D) == q checked by multiply and compare only.
// ----------------------------------------------------------------------------
module spob_cover
   import spob_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  cfg_type               cfg,
   input  logic [3:0]            stage_en,
   input  logic [COORD_BITS-1:0] pix_x,
   input  logic [COORD_BITS-1:0] pix_y,
   input  logic [23:0]           bg,
   output logic                  hit,
   output logic [23:0]           hit_bg
);

   localparam int SW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 3;
   localparam int LW = SW + 18;
   localparam int QW = 2 * SW + 1;

   // ---- derived configuration, refreshed every cycle ----
   logic signed [12:0] x1, y1, x2, y2, xr, lo_c, hi_c;
   logic signed [13:0] dx, dy, ady;
   logic               mode_a, zero_len;

   logic               mode_a_ff, mode_a_in, zero_ff, zero_in;
   logic signed [12:0] x1_ff, y1_ff, base_ff, base_in, c0a_ff, c0a_in;
   logic signed [12:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [14:0] slope_ff, slope_in;
   logic [13:0]        den_ff, den_in;
   logic signed [14:0] rxhi_ff, rxhi_in, ryhi_ff, ryhi_in;
   logic signed [14:0] rxend_ff, rxend_in, ryend_ff, ryend_in;
   logic signed [13:0] e1;
   logic signed [26:0] rr_ff, rr_in;
   logic signed [27:0] r1_ff, r1_in;

   always_comb begin
      if (cfg.anchor_x > cfg.extent_x) begin
         x1 = cfg.extent_x; y1 = cfg.extent_y; x2 = cfg.anchor_x; y2 = cfg.anchor_y;
      end else begin
         x1 = cfg.anchor_x; y1 = cfg.anchor_y; x2 = cfg.extent_x; y2 = cfg.extent_y;
      end
      dx       = 14'(x2) - 14'(x1);
      dy       = 14'(y2) - 14'(y1);
      ady      = dy[13] ? -dy : dy;
      mode_a   = ady < dx;
      zero_len = (dx == 14'sd0) && (dy == 14'sd0);
      xr       = (dy > 14'sd0) ? x1 : x2;
      lo_c     = (dy > 14'sd0) ? y1 : y2;
      hi_c     = (dy > 14'sd0) ? y2 : y1;
      if (mode_a) begin
         base_in  = x1;
         slope_in = 15'(dy);
         c0a_in   = y1;
         den_in   = dx;
         lo_in    = x1;
         hi_in    = x2;
      end else begin
         base_in  = lo_c;
         slope_in = dy[13] ? -15'(dx) : 15'(dx);
         c0a_in   = xr;
         den_in   = ady;
         lo_in    = lo_c;
         hi_in    = hi_c;
      end
      mode_a_in = mode_a;
      zero_in   = zero_len;
      rxend_in  = 15'(cfg.anchor_x) + 15'(cfg.extent_x);
      ryend_in  = 15'(cfg.anchor_y) + 15'(cfg.extent_y);
      rxhi_in   = rxend_in - 15'sd1;
      ryhi_in   = ryend_in - 15'sd1;
      e1        = 14'(cfg.extent_x) + 14'sd1;
      rr_in     = 27'(cfg.extent_x) * 27'(cfg.extent_x);
      r1_in     = 28'(e1) * 28'(e1);
   end

   always_ff @(posedge clock) begin
      mode_a_ff <= mode_a_in;
      zero_ff   <= zero_in;
      x1_ff     <= x1;
      y1_ff     <= y1;
      base_ff   <= base_in;
      c0a_ff    <= c0a_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      slope_ff  <= slope_in;
      den_ff    <= den_in;
      rxhi_ff   <= rxhi_in;
      ryhi_ff   <= ryhi_in;
      rxend_ff  <= rxend_in;
      ryend_ff  <= ryend_in;
      rr_ff     <= rr_in;
      r1_ff     <= r1_in;
   end

   // ---- stage 0: input register ----
   logic [COORD_BITS-1:0] px0_ff, py0_ff;
   logic [23:0]           bg0_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         px0_ff <= pix_x;
         py0_ff <= pix_y;
         bg0_ff <= bg;
      end
   end

   // ---- stage 1: offsets, products, box compares ----
   logic signed [SW-1:0]  pxs, pys, coord, diff, ddx, ddy;
   logic [COORD_BITS-1:0] q;
   logic signed [LW-1:0]  den_s;
   logic signed [LW-1:0]  prod_ff, prod_in, c0_ff, c0_in, m_ff, m_in;
   logic signed [QW-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic q0_ff, q0_in, rng_ff, rng_in, lpt_ff, lpt_in;
   logic pt_ff, pt_in, outl_ff, outl_in, fill_ff, fill_in;
   logic [23:0] bg1_ff;

   assign den_s = $signed(LW'(den_ff));

   always_comb begin
      pxs     = $signed(SW'(px0_ff));
      pys     = $signed(SW'(py0_ff));
      coord   = mode_a_ff ? pxs : pys;
      q       = mode_a_ff ? py0_ff : px0_ff;
      diff    = coord - SW'(base_ff);
      prod_in = LW'(slope_ff) * LW'(diff);
      c0_in   = LW'(c0a_ff) * den_s;
      m_in    = $signed(LW'(q)) * den_s;
      q0_in   = (q == '0);
      rng_in  = (coord >= SW'(lo_ff)) && (coord <= SW'(hi_ff));
      lpt_in  = (pxs == SW'(x1_ff)) && (pys == SW'(y1_ff));
      ddx     = pxs - SW'(cfg.anchor_x);
      ddy     = pys - SW'(cfg.anchor_y);
      sqx_in  = QW'(ddx) * QW'(ddx);
      sqy_in  = QW'(ddy) * QW'(ddy);
      pt_in   = (ddx == '0) && (ddy == '0);
      // outline: horizontal edges, then vertical edges
      outl_in = ((cfg.extent_x > 13'sd0) && (pxs >= SW'(cfg.anchor_x)) &&
                 (pxs <= SW'(rxhi_ff)) &&
                 ((pys == SW'(cfg.anchor_y)) || (pys == SW'(ryhi_ff)))) ||
                ((cfg.extent_y > 13'sd0) && (pys >= SW'(cfg.anchor_y)) &&
                 (pys <= SW'(ryhi_ff)) &&
                 ((pxs == SW'(cfg.anchor_x)) || (pxs == SW'(rxhi_ff))));
      fill_in = (pxs >= SW'(cfg.anchor_x)) && (pxs < SW'(rxend_ff)) &&
                (pys >= SW'(cfg.anchor_y)) && (pys < SW'(ryend_ff));
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         prod_ff <= prod_in;
         c0_ff   <= c0_in;
         m_ff    <= m_in;
         q0_ff   <= q0_in;
         rng_ff  <= rng_in;
         lpt_ff  <= lpt_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         pt_ff   <= pt_in;
         outl_ff <= outl_in;
         fill_ff <= fill_in;
         bg1_ff  <= bg0_ff;
      end
   end

   // ---- stage 2: numerator, bracket top, squared distance ----
   logic signed [LW-1:0] n_ff, n_in, m2_ff, md_ff, md_in;
   logic signed [QW-1:0] d2_ff, d2_in;
   logic q02_ff, rng2_ff, lpt2_ff, pt2_ff, outl2_ff, fill2_ff;
   logic [23:0] bg2_ff;

   assign n_in  = c0_ff + prod_ff;
   assign md_in = m_ff + den_s;
   assign d2_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         n_ff     <= n_in;
         m2_ff    <= m_ff;
         md_ff    <= md_in;
         d2_ff    <= d2_in;
         q02_ff   <= q0_ff;
         rng2_ff  <= rng_ff;
         lpt2_ff  <= lpt_ff;
         pt2_ff   <= pt_ff;
         outl2_ff <= outl_ff;
         fill2_ff <= fill_ff;
         bg2_ff   <= bg1_ff;
      end
   end

   // ---- stage 3: final compares and shape select ----
   logic line_hit, circ_in, ring_in, hit_ff, hit_in;
   logic [23:0] bg3_ff;

   always_comb begin
      // trunc(N/D) == q, D > 0, q >= 0
      line_hit = zero_ff ? lpt2_ff :
                 (rng2_ff && ((q02_ff && (n_ff > -den_s) && (n_ff < den_s)) ||
                              ((n_ff >= m2_ff) && (n_ff < md_ff))));
      circ_in  = !cfg.extent_x[12] && (d2_ff < QW'(r1_ff));
      ring_in  = circ_in && (d2_ff >= QW'(rr_ff));
      case (cfg.shape_kind)
         KIND_POINT:     hit_in = pt2_ff;
         KIND_LINE:      hit_in = line_hit;
         KIND_OUTLINE:   hit_in = outl2_ff;
         KIND_FILL_RECT: hit_in = fill2_ff;
         KIND_RING:      hit_in = ring_in;
         KIND_DISK:      hit_in = circ_in;
         default:        hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         hit_ff <= hit_in;
         bg3_ff <= bg2_ff;
      end
   end

   assign hit    = hit_ff;
   assign hit_bg = bg3_ff;

endmodule

// ===== rtl/spob_blend.sv =====
// ----------------------------------------------------------------------------
// spob_blend
// Alpha blend, stages 4 to 6: weighted sum, reciprocal multiply, output.
// ----------------------------------------------------------------------------
module spob_blend
   import spob_pkg::*;
(
   input  logic        clock,
   input  cfg_type     cfg,
   input  logic [2:0]  stage_en,
   input  logic        hit,
   input  logic [23:0] hit_bg,
   output logic [23:0] out_rgb,
   output logic        out_covered
);

   logic [6:0] alpha, inv_alpha;

   // alpha saturates at 100 percent
   assign alpha     = (cfg.blend_alpha > PCT_FULL) ? PCT_FULL : cfg.blend_alpha;
   assign inv_alpha = PCT_FULL - alpha;

   // ---- stage 4: (100-a)*bg + a*fg per channel ----
   logic [2:0][MIX_BITS-1:0] mix_ff, mix_in;
   logic [2:0][7:0]          bg4_ff;
   logic                     hit4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_in[c] = MIX_BITS'(inv_alpha) * MIX_BITS'(hit_bg[8*c +: 8]) +
                     MIX_BITS'(alpha) * MIX_BITS'(cfg.fill_color[8*c +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mix_ff  <= mix_in;
         bg4_ff  <= hit_bg;
         hit4_ff <= hit;
      end
   end

   // ---- stage 5: divide by 100 as multiply by reciprocal ----
   logic [2:0][SCALED_BITS-1:0] scl_ff, scl_in;
   logic [2:0][7:0]             bg5_ff;
   logic                        hit5_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scl_in[c] = SCALED_BITS'(mix_ff[c]) * SCALED_BITS'(RECIP_100);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         scl_ff  <= scl_in;
         bg5_ff  <= bg4_ff;
         hit5_ff <= hit4_ff;
      end
   end

   // ---- stage 6: output register ----
   logic [2:0][7:0] rgb_ff, rgb_in;
   logic            cov_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rgb_in[c] = hit5_ff ? scl_ff[c][RECIP_SHIFT +: 8] : bg5_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         rgb_ff <= rgb_in;
         cov_ff <= hit5_ff;
      end
   end

   assign out_rgb     = rgb_ff;
   assign out_covered = cov_ff;

endmodule

// ===== rtl/shape_pixel_overlay_blend_unit.sv =====
// ----------------------------------------------------------------------------
// shape_pixel_overlay_blend_unit
// Tests each pixel against the configured shape and blends the fill color
// over covered pixels.
//
//   channel  direction  handshake        word
//   req      in         valid / ready    pix_x, pix_y, bg_red/green/blue
//   rsp      out        valid / ready    out_red/green/blue, covered
//   csr      in         APB-style        7 registers at 4*index
//
// One pixel per cycle sustained while rsp_ready stays high; rsp_valid rises
// once a pixel has passed the seven register stages (input, products, sums,
// compares, blend sum, reciprocal multiply, output).
// Reset clears only the stage valid bits and sets the registers to defaults.
// Each stage holds its word while the next one is full and stalled, so
// bubbles close up and no word is lost or repeated.
// The stages read the configuration as each pixel passes, so pixels in
// flight during a write may see a mix of old and new settings.
// ----------------------------------------------------------------------------
module shape_pixel_overlay_blend_unit
   import spob_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_pix_x,
   input  logic [COORD_BITS-1:0]    req_pix_y,
   input  logic [7:0]               req_bg_red,
   input  logic [7:0]               req_bg_green,
   input  logic [7:0]               req_bg_blue,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   output logic                     rsp_covered,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type           cfg;
   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES:0]   en;
   logic              hit;
   logic [23:0]       hit_bg, out_rgb;

   spob_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // stage enables: a stage loads when empty or when its successor moves
   always_comb begin
      en[STAGES] = rsp_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   spob_cover #(
      .COORD_BITS (COORD_BITS)
   ) u_cover (
      .clock    (clock),
      .cfg      (cfg),
      .stage_en (en[3:0]),
      .pix_x    (req_pix_x),
      .pix_y    (req_pix_y),
      .bg       ({req_bg_red, req_bg_green, req_bg_blue}),
      .hit      (hit),
      .hit_bg   (hit_bg)
   );

   spob_blend u_blend (
      .clock       (clock),
      .cfg         (cfg),
      .stage_en    (en[6:4]),
      .hit         (hit),
      .hit_bg      (hit_bg),
      .out_rgb     (out_rgb),
      .out_covered (rsp_covered)
   );

   assign rsp_out_red   = out_rgb[23:16];
   assign rsp_out_green = out_rgb[15:8];
   assign rsp_out_blue  = out_rgb[7:0];

   // ---- assertions ----
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted word did not enter stage 0");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_ready |-> !req_ready)
      else $error("input accepted while pipeline full and stalled");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && en[4] |=> valid_ff[4])
      else $error("word lost between coverage and blend");

   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !valid_ff[STAGES-2] |=> !rsp_valid)
      else $error("result repeated after delivery");

endmodule

// ===== tb/spob_checker.sv =====
// ----------------------------------------------------------------------------
// spob_checker
// Watches the pixel and result channels of the shape overlay blend unit,
// predicts each result from a shadow copy of the registers and compares
// field by field in order. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module spob_checker
   import spob_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [11:0] req_pix_x,
   input  logic [11:0] req_pix_y,
   input  logic [7:0]  req_bg_red,
   input  logic [7:0]  req_bg_green,
   input  logic [7:0]  req_bg_blue,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_red,
   input  logic [7:0]  rsp_out_green,
   input  logic [7:0]  rsp_out_blue,
   input  logic        rsp_covered,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatch_count,
   output int          pending_pixels
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       covered;
   } pixel_word_type;

   cfg_type        shadow_cfg;
   pixel_word_type blended_pixels[$];

   // line coverage with exact truncating division
   function automatic bit on_segment(longint px, longint py, longint ax, longint ay,
                                     longint ex, longint ey);
      longint x1, y1, x2, y2, dx, dy, ady, n;
      if (ax > ex) begin
         x1 = ex; y1 = ey; x2 = ax; y2 = ay;
      end else begin
         x1 = ax; y1 = ay; x2 = ex; y2 = ey;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx == 0 && dy == 0) return px == x1 && py == y1;
      ady = (dy < 0) ? -dy : dy;
      if (ady < dx) begin
         if (px < x1 || px > x2) return 0;
         n = y1 * dx + dy * (px - x1);
         return py == n / dx;
      end
      if (dy > 0) begin
         if (py < y1 || py > y2) return 0;
         n = x1 * dy + (py - y1) * dx;
      end else begin
         if (py < y2 || py > y1) return 0;
         n = x2 * dy + (py - y2) * dx;
      end
      return px == n / dy;
   endfunction

   function automatic bit shape_covers(longint px, longint py);
      longint ax, ay, ex, ey, d2, r1;
      ax = shadow_cfg.anchor_x;
      ay = shadow_cfg.anchor_y;
      ex = shadow_cfg.extent_x;
      ey = shadow_cfg.extent_y;
      case (shadow_cfg.shape_kind)
         KIND_POINT: return px == ax && py == ay;
         KIND_LINE: return on_segment(px, py, ax, ay, ex, ey);
         KIND_OUTLINE: begin
            if (ex > 0 && px >= ax && px <= ax + ex - 1 &&
                (py == ay || py == ay + ey - 1)) return 1;
            if (ey > 0 && py >= ay && py <= ay + ey - 1 &&
                (px == ax || px == ax + ex - 1)) return 1;
            return 0;
         end
         KIND_FILL_RECT: return px >= ax && px < ax + ex && py >= ay && py < ay + ey;
         KIND_RING, KIND_DISK: begin
            if (ex < 0) return 0;
            d2 = (px - ax) * (px - ax) + (py - ay) * (py - ay);
            r1 = (ex + 1) * (ex + 1);
            if (d2 >= r1) return 0;
            return shadow_cfg.shape_kind == KIND_DISK || d2 >= ex * ex;
         end
         default: return 0;
      endcase
   endfunction

   function automatic logic [7:0] mix_channel(int bg, int fg, int a);
      return 8'((((100 - a) * bg) + a * fg) / 100);
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pixel_word_type want;
      int             a;
      if (reset) begin
         shadow_cfg <= '{shape_kind: KIND_POINT, fill_color: 24'hFFFFFF,
                         blend_alpha: PCT_FULL, default: '0};
         mismatch_count = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[4:2])
               REG_SHAPE_KIND:  shadow_cfg.shape_kind  <= csr_pwdata[2:0];
               REG_ANCHOR_X:    shadow_cfg.anchor_x    <= csr_pwdata[12:0];
               REG_ANCHOR_Y:    shadow_cfg.anchor_y    <= csr_pwdata[12:0];
               REG_EXTENT_X:    shadow_cfg.extent_x    <= csr_pwdata[12:0];
               REG_EXTENT_Y:    shadow_cfg.extent_y    <= csr_pwdata[12:0];
               REG_FILL_COLOR:  shadow_cfg.fill_color  <= csr_pwdata[23:0];
               REG_BLEND_ALPHA: shadow_cfg.blend_alpha <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         // predict each accepted pixel
         if (req_valid && req_ready) begin
            a = (shadow_cfg.blend_alpha > 100) ? 100 : shadow_cfg.blend_alpha;
            if (shape_covers(req_pix_x, req_pix_y)) begin
               want.red   = mix_channel(req_bg_red, shadow_cfg.fill_color[23:16], a);
               want.green = mix_channel(req_bg_green, shadow_cfg.fill_color[15:8], a);
               want.blue  = mix_channel(req_bg_blue, shadow_cfg.fill_color[7:0], a);
               want.covered = 1'b1;
            end else begin
               want = '{req_bg_red, req_bg_green, req_bg_blue, 1'b0};
            end
            blended_pixels.push_back(want);
         end
         // compare each delivered word
         if (rsp_valid && rsp_ready) begin
            if (blended_pixels.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = blended_pixels.pop_front();
               if (rsp_out_red != want.red) report_mismatch("red", rsp_out_red, want.red);
               if (rsp_out_green != want.green)
                  report_mismatch("green", rsp_out_green, want.green);
               if (rsp_out_blue != want.blue)
                  report_mismatch("blue", rsp_out_blue, want.blue);
               if (rsp_covered != want.covered)
                  report_mismatch("covered", rsp_covered, want.covered);
            end
         end
      end
      pending_pixels = blended_pixels.size();
   end

endmodule

// ===== tb/tb_shape_pixel_overlay_blend_unit.sv =====
// ----------------------------------------------------------------------------
// tb_shape_pixel_overlay_blend_unit
// Drives pixels through the shape overlay blend unit under many shape
// settings, with random gaps on both channels; the checker predicts results.
// ----------------------------------------------------------------------------
module tb_shape_pixel_overlay_blend_unit;
   import spob_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_pix_x = '0;
   logic [11:0] req_pix_y = '0;
   logic [7:0]  req_bg_red = '0;
   logic [7:0]  req_bg_green = '0;
   logic [7:0]  req_bg_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_red, rsp_out_green, rsp_out_blue;
   logic        rsp_covered;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count;
   int          pending_pixels;
   int          cycle_count = 0;
   int          rsp_wait = 0;
   bit          stimulus_done = 0;

   always #5 clock = ~clock;

   shape_pixel_overlay_blend_unit dut (.*);

   spob_checker checker_i (.*);

   // result-side stall: after each word, drop ready for a randomly drawn stall
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
      end else if (rsp_valid) begin
         stall = $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_wait  <= stall - 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait until every pixel has come back, then let the pipeline drain
   task automatic drain_pipeline();
      @(posedge clock);
      while (pending_pixels != 0) @(posedge clock);
      repeat (STAGES + 4) @(posedge clock);
   endtask

   task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [23:0] bg);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pix_x    <= x;
      req_pix_y    <= y;
      req_bg_red   <= bg[23:16];
      req_bg_green <= bg[15:8];
      req_bg_blue  <= bg[7:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_shape(logic [2:0] kind, logic [12:0] ax, logic [12:0] ay,
                             logic [12:0] ex, logic [12:0] ey, logic [23:0] color,
                             logic [6:0] alpha);
      req_valid <= 1'b0;
      drain_pipeline();
      write_register(REG_SHAPE_KIND, 32'(kind));
      write_register(REG_ANCHOR_X, 32'(ax));
      write_register(REG_ANCHOR_Y, 32'(ay));
      write_register(REG_EXTENT_X, 32'(ex));
      write_register(REG_EXTENT_Y, 32'(ey));
      write_register(REG_FILL_COLOR, 32'(color));
      write_register(REG_BLEND_ALPHA, 32'(alpha));
   endtask

   // pixel near the shape most of the time, anywhere otherwise
   function automatic logic [11:0] near_coord(logic signed [12:0] center, int spread);
      int v;
      if ($urandom_range(0, 4) == 0) return 12'($urandom);
      v = int'(center) + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   initial begin
      logic [2:0]  kind;
      logic [12:0] ax, ay, ex, ey;
      int          span;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: opaque white point at the origin
      send_pixel(12'd0, 12'd0, 24'h123456);
      send_pixel(12'd1, 12'd0, 24'hFFFFFF);
      send_pixel(12'd4095, 12'd4095, 24'h000000);
      // line, zero-length line, outline, ring, negative radius, disk, kind 7, fill rect
      load_shape(KIND_LINE, 13'd10, 13'd10, 13'd2, 13'd30, 24'h000000, 7'd50);
      send_pixel(12'd10, 12'd10, 24'hFF00FF);
      send_pixel(12'd2, 12'd30, 24'h00FF00);
      send_pixel(12'd6, 12'd20, 24'hFFFFFF);
      load_shape(KIND_LINE, 13'd7, 13'd7, 13'd7, 13'd7, 24'hABCDEF, 7'd127);
      send_pixel(12'd7, 12'd7, 24'h010203);
      send_pixel(12'd8, 12'd7, 24'h010203);
      load_shape(KIND_OUTLINE, 13'd4, 13'd4, 13'd5, 13'd3, 24'hFF8000, 7'd0);
      send_pixel(12'd4, 12'd4, 24'hFFFFFF);
      send_pixel(12'd8, 12'd6, 24'h00FF00);
      send_pixel(12'd6, 12'd5, 24'h00FF00);
      load_shape(KIND_RING, 13'd20, 13'd20, 13'd5, 13'd0, 24'h00FFFF, 7'd33);
      send_pixel(12'd25, 12'd20, 24'h808080);
      send_pixel(12'd20, 12'd20, 24'h808080);
      load_shape(KIND_DISK, 13'h1000, 13'h1FFF, 13'h1FFF, 13'h0FFF, 24'hFFFFFF, 7'd100);
      send_pixel(12'd0, 12'd0, 24'h000000);
      load_shape(KIND_DISK, 13'd0, 13'd0, 13'd4095, 13'd0, 24'h0F0F0F, 7'd99);
      send_pixel(12'd4095, 12'd0, 24'hFFFFFF);
      send_pixel(12'd2000, 12'd2000, 24'hF0F0F0);
      load_shape(3'd7, 13'd0, 13'd0, 13'd100, 13'd100, 24'hFFFFFF, 7'd100);
      send_pixel(12'd0, 12'd0, 24'h000000);
      load_shape(KIND_FILL_RECT, 13'h1FF0, 13'h1FF0, 13'd40, 13'd40, 24'h112233, 7'd1);
      send_pixel(12'd0, 12'd0, 24'hFFFFFF);
      send_pixel(12'd23, 12'd23, 24'hFFFFFF);
      send_pixel(12'd24, 12'd0, 24'hFFFFFF);

      // random phases of 50 pixels each
      repeat (31) begin
         kind = 3'($urandom_range(0, 7));
         span = ($urandom_range(0, 3) == 0) ? 4096 : 40;
         ax = 13'($urandom_range(0, span) - ($urandom_range(0, 5) == 0 ? span / 4 : 0));
         ay = 13'($urandom_range(0, span) - ($urandom_range(0, 5) == 0 ? span / 4 : 0));
         ex = 13'($urandom_range(0, span) - ($urandom_range(0, 5) == 0 ? span / 4 : 0));
         ey = 13'($urandom_range(0, span) - ($urandom_range(0, 5) == 0 ? span / 4 : 0));
         if ($urandom_range(0, 7) == 0) ax = 13'($urandom);
         load_shape(kind, ax, ay, ex, ey, 24'($urandom), 7'($urandom_range(0, 127)));
         repeat (50) send_pixel(near_coord(ax, 20), near_coord(ay, 20), 24'($urandom));
      end

      req_valid <= 1'b0;
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
